>>> hdl/lpbm_pkg.sv
// lpbm_pkg: shared types and constants for the layer priority blend mixer
// used by lpbm_cell, lpbm_blend and layer_priority_blend_mixer; no dependencies
package lpbm_pkg;

    localparam int NumLayersDefault = 7;
    localparam int RegLayers        = 7;
    localparam int PriW             = 3;
    localparam int RatioW           = 6;
    localparam int RgbW             = 24;
    localparam int PixW             = 25;
    localparam int CfgIdxW          = 3;
    localparam int CfgDataW         = 42;
    localparam int MaskW            = 7;
    localparam int PriRegW          = 21;
    localparam int RatioRegW        = 42;

    localparam logic [5:0] RatioFull = 6'd32;

    localparam logic [MaskW-1:0]     EnableReset = 7'd64;
    localparam logic [PriRegW-1:0]   PriReset    = '0;
    localparam logic [MaskW-1:0]     CcReset     = '0;
    localparam logic [RatioRegW-1:0] RatioReset  = '0;
    localparam logic [RgbW-1:0]      BackReset   = '0;

    localparam logic [CfgIdxW-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PRI    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_CC     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_RATIO  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_BACK   = 3'd4;

    typedef logic [PixW-1:0] t_pix;

    typedef struct packed {
        logic [PixW-1:0] pixel_nbg0;
        logic [PixW-1:0] pixel_nbg1;
        logic [PixW-1:0] pixel_nbg2;
        logic [PixW-1:0] pixel_nbg3;
        logic [PixW-1:0] pixel_rotation;
        logic [PixW-1:0] pixel_sprite;
        logic [PixW-1:0] pixel_backdrop;
    } t_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_out;

    typedef struct packed {
        logic              en;
        logic [PriW-1:0]   pri;
        logic              cc;
        logic [RatioW-1:0] ratio;
    } t_layer_cfg;

    typedef struct packed {
        logic              have_top;
        logic [PriW-1:0]   top_pri;
        logic [RgbW-1:0]   top_rgb;
        logic              top_cc;
        logic [RatioW-1:0] top_ratio;
        logic              have_sec;
        logic [PriW-1:0]   sec_pri;
        logic [RgbW-1:0]   sec_rgb;
    } t_acc;

endpackage

>>> hdl/layer_priority_blend_mixer.sv
// layer_priority_blend_mixer: top level of the priority layer compositor
// depends on lpbm_pkg, lpbm_cell and lpbm_blend

// Takes one request per clock while o_in_ready is high and returns one output
// pixel per request, in order. Each request walks a chain of NUM_LAYERS cells,
// one per layer, each keeping the best and second-best layer seen so far, then one
// blend stage with the output register. Every stage holds its own valid bit, so a
// stall on the output only stops the stages that are full. Layers from index 7
// upward have no register bits and stay disabled. Configuration is written through
// i_cfg_we/i_cfg_idx/i_cfg_data and must only change while no request is in flight.
module layer_priority_blend_mixer #(
    parameter int NUM_LAYERS = lpbm_pkg::NumLayersDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpbm_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [lpbm_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lpbm_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lpbm_pkg::t_out                 o_out_data
);

    logic [lpbm_pkg::MaskW-1:0]     r_enable;
    logic [lpbm_pkg::PriRegW-1:0]   r_pri;
    logic [lpbm_pkg::MaskW-1:0]     r_cc;
    logic [lpbm_pkg::RatioRegW-1:0] r_ratio;
    logic [lpbm_pkg::RgbW-1:0]      r_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= lpbm_pkg::EnableReset;
            r_pri    <= lpbm_pkg::PriReset;
            r_cc     <= lpbm_pkg::CcReset;
            r_ratio  <= lpbm_pkg::RatioReset;
            r_back   <= lpbm_pkg::BackReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpbm_pkg::CFG_ENABLE: r_enable <= i_cfg_data[lpbm_pkg::MaskW-1:0];
                lpbm_pkg::CFG_PRI:    r_pri    <= i_cfg_data[lpbm_pkg::PriRegW-1:0];
                lpbm_pkg::CFG_CC:     r_cc     <= i_cfg_data[lpbm_pkg::MaskW-1:0];
                lpbm_pkg::CFG_RATIO:  r_ratio  <= i_cfg_data[lpbm_pkg::RatioRegW-1:0];
                lpbm_pkg::CFG_BACK:   r_back   <= i_cfg_data[lpbm_pkg::RgbW-1:0];
                default: ;
            endcase
        end
    end

    logic                 stg_valid [NUM_LAYERS+1];
    logic                 stg_ready [NUM_LAYERS+1];
    lpbm_pkg::t_acc       stg_acc   [NUM_LAYERS+1];
    lpbm_pkg::t_pix       stg_pix   [NUM_LAYERS+1][NUM_LAYERS];
    lpbm_pkg::t_pix       in_pix    [lpbm_pkg::RegLayers];
    lpbm_pkg::t_layer_cfg layer_cfg [NUM_LAYERS];

    assign in_pix[0] = i_in_data.pixel_nbg0;
    assign in_pix[1] = i_in_data.pixel_nbg1;
    assign in_pix[2] = i_in_data.pixel_nbg2;
    assign in_pix[3] = i_in_data.pixel_nbg3;
    assign in_pix[4] = i_in_data.pixel_rotation;
    assign in_pix[5] = i_in_data.pixel_sprite;
    assign in_pix[6] = i_in_data.pixel_backdrop;

    assign stg_valid[0] = i_in_valid;
    assign o_in_ready   = stg_ready[0];
    assign stg_acc[0]   = '0;

    for (genvar g = 0; g < NUM_LAYERS; g++) begin : g_layer
        if (g < lpbm_pkg::RegLayers) begin : g_reg
            assign stg_pix[0][g]       = in_pix[g];
            assign layer_cfg[g].en     = r_enable[g];
            assign layer_cfg[g].pri    = r_pri[lpbm_pkg::PriW*g +: lpbm_pkg::PriW];
            assign layer_cfg[g].cc     = r_cc[g];
            assign layer_cfg[g].ratio  = r_ratio[lpbm_pkg::RatioW*g +: lpbm_pkg::RatioW];
        end else begin : g_none
            assign stg_pix[0][g] = '0;
            assign layer_cfg[g]  = '0;
        end

        lpbm_cell #(
            .NL  (NUM_LAYERS),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_acc   (stg_acc[g]),
            .i_pix   (stg_pix[g]),
            .i_layer (layer_cfg[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_acc   (stg_acc[g+1]),
            .o_pix   (stg_pix[g+1])
        );
    end

    lpbm_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[NUM_LAYERS]),
        .o_ready (stg_ready[NUM_LAYERS]),
        .i_acc   (stg_acc[NUM_LAYERS]),
        .i_back  (r_back),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_out   (o_out_data)
    );

endmodule

>>> hdl/lpbm_cell.sv
// lpbm_cell: one layer stage of the priority chain, keeps the best two layers
// depends on lpbm_pkg
module lpbm_cell #(
    parameter int NL  = lpbm_pkg::NumLayersDefault,
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  lpbm_pkg::t_acc      i_acc,
    input  lpbm_pkg::t_pix      i_pix [NL],
    input  lpbm_pkg::t_layer_cfg i_layer,
    output logic                o_valid,
    input  logic                i_ready,
    output lpbm_pkg::t_acc      o_acc,
    output lpbm_pkg::t_pix      o_pix [NL]
);

    logic           r_valid;
    lpbm_pkg::t_acc r_acc;
    lpbm_pkg::t_acc n_acc;
    lpbm_pkg::t_pix r_pix [NL];
    logic           live;
    logic           advance;

    assign live    = i_layer.en & i_pix[IDX][lpbm_pkg::PixW-1];
    assign advance = !r_valid || i_ready;
    assign o_ready = advance;

    always_comb begin
        n_acc = i_acc;
        if (live) begin
            if (!i_acc.have_top || (i_layer.pri > i_acc.top_pri)) begin
                n_acc.have_sec  = i_acc.have_top;
                n_acc.sec_pri   = i_acc.top_pri;
                n_acc.sec_rgb   = i_acc.top_rgb;
                n_acc.have_top  = 1'b1;
                n_acc.top_pri   = i_layer.pri;
                n_acc.top_rgb   = i_pix[IDX][lpbm_pkg::RgbW-1:0];
                n_acc.top_cc    = i_layer.cc;
                n_acc.top_ratio = i_layer.ratio;
            end else if (!i_acc.have_sec || (i_layer.pri > i_acc.sec_pri)) begin
                n_acc.have_sec = 1'b1;
                n_acc.sec_pri  = i_layer.pri;
                n_acc.sec_rgb  = i_pix[IDX][lpbm_pkg::RgbW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_acc <= n_acc;
            r_pix <= i_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_pix   = r_pix;

endmodule

>>> hdl/lpbm_blend.sv
// lpbm_blend: final choice and per-channel blend into the output register
// depends on lpbm_pkg
module lpbm_blend (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  lpbm_pkg::t_acc             i_acc,
    input  logic [lpbm_pkg::RgbW-1:0]  i_back,
    output logic                       o_valid,
    input  logic                       i_ready,
    output lpbm_pkg::t_out             o_out
);

    function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                       input logic [5:0] ra, input logic [5:0] rb);
        logic [13:0] sum;
        sum = 14'(a) * 14'(ra) + 14'(b) * 14'(rb);
        return sum[12:5];
    endfunction

    logic                      r_valid;
    lpbm_pkg::t_out            r_out;
    logic [5:0]                ratio;
    logic [5:0]                inv;
    logic [lpbm_pkg::RgbW-1:0] rgb;
    logic                      advance;

    assign advance = !r_valid || i_ready;
    assign o_ready = advance;
    assign ratio   = (i_acc.top_ratio > lpbm_pkg::RatioFull) ? lpbm_pkg::RatioFull
                                                             : i_acc.top_ratio;
    assign inv     = lpbm_pkg::RatioFull - ratio;

    always_comb begin
        if (!i_acc.have_top) begin
            rgb = i_back;
        end else if (!i_acc.top_cc || !i_acc.have_sec) begin
            rgb = i_acc.top_rgb;
        end else begin
            rgb = {mix(i_acc.top_rgb[23:16], i_acc.sec_rgb[23:16], ratio, inv),
                   mix(i_acc.top_rgb[15:8],  i_acc.sec_rgb[15:8],  ratio, inv),
                   mix(i_acc.top_rgb[7:0],   i_acc.sec_rgb[7:0],   ratio, inv)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_out.out_red   <= rgb[23:16];
            r_out.out_green <= rgb[15:8];
            r_out.out_blue  <= rgb[7:0];
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

>>> test/layer_priority_blend_mixer_tb.sv
// layer_priority_blend_mixer_tb: self-checking bench for the priority layer blend mixer
// directed rows, then random layer sets under several idle patterns, each result checked
// against its row's pixel or mix_pixel; depends on lpbm_pkg and layer_priority_blend_mixer
module layer_priority_blend_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Layers     = lpbm_pkg::NumLayersDefault;
    localparam int WatchLimit = 2000;
    localparam int PerSetting = 92;

    localparam int MaskW     = lpbm_pkg::MaskW;
    localparam int PriRegW   = lpbm_pkg::PriRegW;
    localparam int RatioRegW = lpbm_pkg::RatioRegW;
    localparam int RgbW      = lpbm_pkg::RgbW;
    localparam int CfgIdxW   = lpbm_pkg::CfgIdxW;
    localparam int CfgDataW  = lpbm_pkg::CfgDataW;
    localparam int PriW      = lpbm_pkg::PriW;
    localparam int PixW      = lpbm_pkg::PixW;
    localparam int RatioW    = lpbm_pkg::RatioW;

    localparam lpbm_pkg::t_in Stack = '{
        {1'b1, 24'h102030}, {1'b1, 24'h405060}, {1'b1, 24'h708090}, {1'b1, 24'hA0B0C0},
        {1'b1, 24'hD0E0F0}, {1'b1, 24'hF01020}, {1'b1, 24'hC0D0E0}
    };

    typedef struct {
        logic [MaskW-1:0]     en;
        logic [PriRegW-1:0]   pri;
        logic [MaskW-1:0]     cc;
        logic [RatioRegW-1:0] ratio;
        logic [RgbW-1:0]      back;
        lpbm_pkg::t_in        pix;
        bit                   known;
        lpbm_pkg::t_out       pixel;
    } t_row;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx   = '0;
    logic [CfgDataW-1:0] i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    lpbm_pkg::t_in       i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    lpbm_pkg::t_out      o_out_data;

    logic                 typed_valid = 1'b0;
    lpbm_pkg::t_out       typed_pixel = '0;

    logic [MaskW-1:0]     enable_reg = lpbm_pkg::EnableReset;
    logic [PriRegW-1:0]   prio_reg   = lpbm_pkg::PriReset;
    logic [MaskW-1:0]     calc_reg   = lpbm_pkg::CcReset;
    logic [RatioRegW-1:0] ratio_reg  = lpbm_pkg::RatioReset;
    logic [RgbW-1:0]      back_reg   = lpbm_pkg::BackReset;

    lpbm_pkg::t_out pending_pixels [$];
    t_row           directed_rows [$];
    lpbm_pkg::t_out want;
    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    int             fail_count    = 0;
    int             idle_cycles   = 0;

    layer_priority_blend_mixer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic lpbm_pkg::t_out mix_pixel(input lpbm_pkg::t_in d);
        lpbm_pkg::t_pix  pix [Layers];
        logic [PriW-1:0] p;
        logic [PriW-1:0] top_p;
        logic [PriW-1:0] sec_p;
        int              top;
        int              sec;
        bit              have_top;
        bit              have_sec;
        int unsigned     ratio;
        int unsigned     a;
        int unsigned     b;
        lpbm_pkg::t_out  res;
        pix = '{d.pixel_nbg0, d.pixel_nbg1, d.pixel_nbg2, d.pixel_nbg3,
                d.pixel_rotation, d.pixel_sprite, d.pixel_backdrop};
        have_top = 1'b0;
        have_sec = 1'b0;
        top      = 0;
        sec      = 0;
        top_p    = '0;
        sec_p    = '0;
        for (int i = 0; i < Layers; i++) begin
            if (!(enable_reg[i] && pix[i][PixW-1])) continue;
            p = prio_reg[PriW*i +: PriW];
            if (!have_top || p > top_p) begin
                have_top = 1'b1;
                top_p    = p;
                top      = i;
            end
        end
        if (!have_top) return back_reg;
        if (!calc_reg[top]) return pix[top][RgbW-1:0];
        for (int i = 0; i < Layers; i++) begin
            if (i == top || !(enable_reg[i] && pix[i][PixW-1])) continue;
            p = prio_reg[PriW*i +: PriW];
            if (p <= top_p && (!have_sec || p > sec_p)) begin
                have_sec = 1'b1;
                sec_p    = p;
                sec      = i;
            end
        end
        if (!have_sec) return pix[top][RgbW-1:0];
        ratio = ratio_reg[RatioW*top +: RatioW];
        if (ratio > lpbm_pkg::RatioFull) ratio = lpbm_pkg::RatioFull;
        for (int ch = 0; ch < 3; ch++) begin
            a = pix[top][8*ch +: 8];
            b = pix[sec][8*ch +: 8];
            res[8*ch +: 8] = 8'((a * ratio + b * (lpbm_pkg::RatioFull - ratio))
                                / lpbm_pkg::RatioFull);
        end
        return res;
    endfunction

    function automatic void add_row(input logic [MaskW-1:0] en, input logic [PriRegW-1:0] pri,
                                    input logic [MaskW-1:0] cc,
                                    input logic [RatioRegW-1:0] ratio,
                                    input logic [RgbW-1:0] back, input lpbm_pkg::t_in pix,
                                    input bit known, input lpbm_pkg::t_out pixel);
        t_row r;
        r.en    = en;
        r.pri   = pri;
        r.cc    = cc;
        r.ratio = ratio;
        r.back  = back;
        r.pix   = pix;
        r.known = known;
        r.pixel = pixel;
        directed_rows.push_back(r);
    endfunction

    function automatic lpbm_pkg::t_in rand_layers();
        lpbm_pkg::t_pix  p [Layers];
        logic [RgbW-1:0] rgb;
        for (int i = 0; i < Layers; i++) begin
            case ($urandom_range(0, 7))
                0:       rgb = '0;
                1:       rgb = '1;
                default: rgb = RgbW'($urandom());
            endcase
            p[i] = {1'($urandom_range(0, 99) < 70), rgb};
        end
        return '{p[0], p[1], p[2], p[3], p[4], p[5], p[6]};
    endfunction

    // unused bits above each register width carry garbage, plus one write to a spare index
    task automatic load_regs(input logic [MaskW-1:0] en, input logic [PriRegW-1:0] pri,
                             input logic [MaskW-1:0] cc, input logic [RatioRegW-1:0] ratio,
                             input logic [RgbW-1:0] back);
        logic [CfgIdxW-1:0]  idx [6];
        logic [CfgDataW-1:0] val [6];
        idx = '{lpbm_pkg::CFG_BACK + CfgIdxW'($urandom_range(1, 3)), lpbm_pkg::CFG_ENABLE,
                lpbm_pkg::CFG_PRI, lpbm_pkg::CFG_CC, lpbm_pkg::CFG_RATIO, lpbm_pkg::CFG_BACK};
        for (int k = 0; k < 6; k++) val[k] = CfgDataW'({$urandom(), $urandom()});
        val[1][MaskW-1:0]   = en;
        val[2][PriRegW-1:0] = pri;
        val[3][MaskW-1:0]   = cc;
        val[4]              = ratio;
        val[5][RgbW-1:0]    = back;
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 6; k++) begin
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
            case (idx[k])
                lpbm_pkg::CFG_ENABLE: enable_reg = val[k][MaskW-1:0];
                lpbm_pkg::CFG_PRI:    prio_reg   = val[k][PriRegW-1:0];
                lpbm_pkg::CFG_CC:     calc_reg   = val[k][MaskW-1:0];
                lpbm_pkg::CFG_RATIO:  ratio_reg  = val[k][RatioRegW-1:0];
                lpbm_pkg::CFG_BACK:   back_reg   = val[k][RgbW-1:0];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(input lpbm_pkg::t_in d, input bit known,
                                input lpbm_pkg::t_out pixel);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_data   <= d;
        typed_valid <= known;
        typed_pixel <= pixel;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (Layers + 2) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pending_pixels.push_back(typed_valid ? typed_pixel : mix_pixel(i_in_data));
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("result with no request outstanding: %h", o_out_data);
                    fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_out_data.out_red !== want.out_red) begin
                        $error("out_red expected %0h got %0h", want.out_red, o_out_data.out_red);
                        fail_count++;
                    end
                    if (o_out_data.out_green !== want.out_green) begin
                        $error("out_green expected %0h got %0h", want.out_green,
                               o_out_data.out_green);
                        fail_count++;
                    end
                    if (o_out_data.out_blue !== want.out_blue) begin
                        $error("out_blue expected %0h got %0h", want.out_blue,
                               o_out_data.out_blue);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchLimit) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_row                 r;
        int                   send_tab [4];
        int                   stall_tab [4];
        int                   k;
        logic [RatioRegW-1:0] rv;
        send_tab  = '{0, 49, 0, 27};
        stall_tab = '{0, 0, 49, 27};

        // after reset only the back layer is on
        add_row(lpbm_pkg::EnableReset, '0, '0, '0, '0, Stack, 1, 24'hC0D0E0);
        add_row(lpbm_pkg::EnableReset, '0, '0, '0, '0, '0, 1, 24'h000000);
        // nothing enabled, back color shows
        add_row(7'h00, '0, '0, '0, 24'hFFFFFF, '1, 1, 24'hFFFFFF);
        // equal priorities, lowest layer wins
        add_row(7'h7F, '0, '0, '0, '0, Stack, 1, 24'h102030);
        add_row(7'h7F, '1, '0, '0, '0, Stack, 1, 24'h102030);
        add_row(7'h7F, 21'h1C0000, '0, '0, '0, Stack, 1, 24'hC0D0E0);
        // full and clamped ratio keep the top pixel
        add_row(7'h7F, 21'h1C0000, 7'h7F, {7{6'd32}}, '0, Stack, 1, 24'hC0D0E0);
        add_row(7'h7F, 21'h1C0000, 7'h7F, '1, '0, Stack, 1, 24'hC0D0E0);
        add_row(7'h7F, 21'h1C0000, 7'h7F, '0, '0, Stack, 0, '0);
        add_row(7'h7F, 21'h1C0000, 7'h7F, {7{6'd16}}, '0, Stack, 0, '0);
        add_row(7'h7F, '0, 7'h7F, {7{6'd1}}, '0,
                '{{1'b1, 24'hFFFFFF}, {1'b1, 24'h000000}, 25'h0, 25'h0, 25'h0, 25'h0, 25'h0},
                0, '0);
        add_row(7'h7F, '0, 7'h7F, {7{6'd1}}, '0,
                '{{1'b1, 24'h000000}, {1'b1, 24'hFFFFFF}, 25'h0, 25'h0, 25'h0, 25'h0, 25'h0},
                0, '0);
        // lone opaque layer has no partner
        add_row(7'h7F, '0, 7'h7F, {7{6'd1}}, '0,
                '{25'h0, 25'h0, {1'b1, 24'h5A5A5A}, 25'h0, 25'h0, 25'h0, 25'h0},
                1, 24'h5A5A5A);
        add_row(7'h5F, 21'h030B20, 7'h7F, {7{6'd20}}, '0, Stack, 0, '0);
        add_row(7'h57, 21'h030B20, 7'h7F, {7{6'd20}}, '0, Stack, 0, '0);
        add_row(7'h7F, 21'h007000, 7'h10, RatioRegW'(33) << 24, '0, Stack, 1, 24'hD0E0F0);
        // color calc off on the top layer only
        add_row(7'h7F, 21'h007000, 7'h6F, RatioRegW'(33) << 24, '0, Stack, 1, 24'hD0E0F0);
        add_row(7'h7F, '0, '0, '0, 24'hABCDEF, '{default: 25'h0AAAAAA}, 1, 24'hABCDEF);
        add_row(7'h7F, 21'h0AB35C, 7'h7F, {7{6'd7}}, '0, '1, 0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            r = directed_rows[n];
            if ({r.en, r.pri, r.cc, r.ratio, r.back} !=
                {enable_reg, prio_reg, calc_reg, ratio_reg, back_reg}) begin
                drain();
                load_regs(r.en, r.pri, r.cc, r.ratio, r.back);
            end
            send_request(r.pix, r.known, '0 | r.pixel);
        end

        for (int mode = 0; mode < 4; mode++) begin
            for (int s = 0; s < 3; s++) begin
                k = mode * 3 + s;
                drain();
                send_idle_pct = send_tab[mode];
                stall_pct     = stall_tab[mode];
                if (k == 0) begin
                    load_regs('1, '1, '1, '1, '1);
                end else if (k == 1) begin
                    load_regs('1, '0, '1, '0, '0);
                end else begin
                    for (int f = 0; f < Layers; f++) begin
                        rv[RatioW*f +: RatioW] = ($urandom_range(0, 9) == 0) ?
                            RatioW'($urandom_range(33, 63)) : RatioW'($urandom_range(0, 32));
                    end
                    load_regs(MaskW'($urandom() | $urandom()), PriRegW'($urandom()),
                              MaskW'($urandom()), rv, RgbW'($urandom()));
                end
                repeat (PerSetting) send_request(rand_layers(), 0, '0);
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> layer_priority_blend_mixer.f
hdl/lpbm_pkg.sv
hdl/lpbm_cell.sv
hdl/lpbm_blend.sv
hdl/layer_priority_blend_mixer.sv
test/layer_priority_blend_mixer_tb.sv
